/* src/epsm_pkg.sv */
// Package for the encoder period speed meter: widths, codes and the microcode ROM.
// Depends on nothing; used by encoder_period_speed_meter.
package epsm_pkg;

  localparam int MAX_PERIODS = 16;
  localparam int IDX_W       = $clog2(MAX_PERIODS);
  localparam int TIME_W      = 32;
  localparam int PPR_W       = 16;
  localparam int SAMPLES_W   = 5;
  localparam int SUM_W       = TIME_W + IDX_W;      // sum of up to MAX_PERIODS-1 periods
  localparam int DEN_W       = SUM_W + PPR_W;
  localparam int K_W         = 39;
  localparam int NUM_W       = K_W + IDX_W;
  localparam int N_W         = DEN_W + 1;           // num + den/2
  localparam int Q_W         = 32;
  localparam int BIT_W       = $clog2(Q_W);

  localparam logic [K_W-1:0] SPEED_K = 39'd411774832291;  // round(2*pi*1e6*2^16)
  localparam logic [PPR_W-1:0] PPR_RESET = 16'd20;

  localparam logic [1:0] FUNC_EDGE  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_READ   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ACC    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ROUND  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SATCHK = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUTQ   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMPTY  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUTSAT = 4'd10;

  localparam logic [3:0] OP_IDLE   = 4'd0;
  localparam logic [3:0] OP_INIT   = 4'd1;
  localparam logic [3:0] OP_READ   = 4'd2;
  localparam logic [3:0] OP_ACC    = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_ROUND  = 4'd5;
  localparam logic [3:0] OP_SATCHK = 4'd6;
  localparam logic [3:0] OP_DIV    = 4'd7;
  localparam logic [3:0] OP_OUTQ   = 4'd8;
  localparam logic [3:0] OP_EMPTY  = 4'd9;
  localparam logic [3:0] OP_OUTSAT = 4'd10;

  // jump to target when the condition holds, else fall through
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NOQUERY  = 3'd2;
  localparam logic [2:0] COND_CNT_ZERO = 3'd3;
  localparam logic [2:0] COND_MORE     = 3'd4;
  localparam logic [2:0] COND_SAT      = 3'd5;
  localparam logic [2:0] COND_DIV_MORE = 3'd6;

  typedef struct packed {
    logic [3:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:   w = '{OP_IDLE,   COND_NOQUERY,  STEP_IDLE};
      STEP_INIT:   w = '{OP_INIT,   COND_CNT_ZERO, STEP_EMPTY};
      STEP_READ:   w = '{OP_READ,   COND_NONE,     STEP_IDLE};
      STEP_ACC:    w = '{OP_ACC,    COND_MORE,     STEP_READ};
      STEP_MUL:    w = '{OP_MUL,    COND_NONE,     STEP_IDLE};
      STEP_ROUND:  w = '{OP_ROUND,  COND_NONE,     STEP_IDLE};
      STEP_SATCHK: w = '{OP_SATCHK, COND_SAT,      STEP_OUTSAT};
      STEP_DIV:    w = '{OP_DIV,    COND_DIV_MORE, STEP_DIV};
      STEP_OUTQ:   w = '{OP_OUTQ,   COND_ALWAYS,   STEP_IDLE};
      STEP_EMPTY:  w = '{OP_EMPTY,  COND_ALWAYS,   STEP_IDLE};
      STEP_OUTSAT: w = '{OP_OUTSAT, COND_ALWAYS,   STEP_IDLE};
      default:     w = '{OP_IDLE,   COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* src/encoder_period_speed_meter.sv */
// Encoder period speed meter: microcoded sequencer over a period RAM and a
// shift-subtract divider. Depends on epsm_pkg and epsm_ram.
// Edge and clear words are handled in the idle step; busy stays low for them.
// A query with n stored periods sums them over the registered-read RAM (read step,
// then accumulate step, per entry), then multiplies, rounds, checks saturation and
// divides (32 steps); saturation skips the divider, no data skips it all. busy drops in
// the strobe cycle, so the next word can be taken there. The receiver cannot stall.
// Synchronous reset: 20 pulses per rev, phase, count, start time and sequencer cleared.
module encoder_period_speed_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [epsm_pkg::TIME_W-1:0]   time_us,
  input  logic                          cfg_we,
  input  logic [epsm_pkg::PPR_W-1:0]    cfg_wdata,
  output logic                          result_valid,
  output logic [epsm_pkg::Q_W-1:0]      speed_q16,
  output logic                          no_data,
  output logic [epsm_pkg::SAMPLES_W-1:0] samples_used
);
  import epsm_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucode_t            uw;

  logic [PPR_W-1:0]  ppr;
  logic              phase;
  logic [TIME_W-1:0] start_time;
  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [SUM_W-1:0]  sum;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [N_W-1:0]    nreg;
  logic [DEN_W-1:0]  rem;
  logic [Q_W-1:0]    qreg;
  logic [BIT_W-1:0]  bitcnt;

  logic              accept;
  logic              store_we;
  logic [TIME_W-1:0] rdata;
  logic [N_W-1:0]    trial;
  logic              trial_ge;
  logic              sat_hit;
  logic              cond_hit;

  assign uw       = ucode_rom(pc);
  assign busy     = (pc != STEP_IDLE);
  assign accept   = start && !busy;
  assign store_we = accept && (func == FUNC_EDGE) && phase;
  assign trial    = {rem, qreg[Q_W-1]};
  assign trial_ge = (trial >= N_W'(den));
  assign sat_hit  = (DEN_W'(nreg[N_W-1:Q_W]) >= den);

  epsm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PERIODS)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count),
    .wdata (time_us - start_time),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    unique case (uw.cond)
      COND_NONE:     cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NOQUERY:  cond_hit = !(accept && (func == FUNC_QUERY));
      COND_CNT_ZERO: cond_hit = (count == '0);
      COND_MORE:     cond_hit = ({1'b0, idx} + 1'b1) < {1'b0, count};
      COND_SAT:      cond_hit = sat_hit;
      COND_DIV_MORE: cond_hit = (bitcnt != BIT_W'(Q_W - 1));
      default:       cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? uw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= STEP_IDLE;
      ppr          <= PPR_RESET;
      phase        <= 1'b0;
      start_time   <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      pc           <= pc_next;
      result_valid <= (uw.op == OP_OUTQ) || (uw.op == OP_EMPTY) || (uw.op == OP_OUTSAT);
      if (cfg_we) begin
        ppr <= cfg_wdata;
      end
      unique case (uw.op)
        OP_IDLE: begin
          if (accept && (func == FUNC_EDGE)) begin
            if (!phase) begin
              start_time <= time_us;
              phase      <= 1'b1;
            end else begin
              count <= (count == IDX_W'(MAX_PERIODS - 1)) ? '0 : count + 1'b1;
              phase <= 1'b0;
            end
          end else if (accept && (func == FUNC_CLEAR)) begin
            count <= '0;
            phase <= 1'b0;
          end
        end
        OP_INIT: begin
          idx <= '0;
          sum <= '0;
          num <= '0;
        end
        OP_READ: begin
        end
        OP_ACC: begin
          sum <= sum + SUM_W'(rdata);
          num <= num + NUM_W'(SPEED_K);
          idx <= idx + 1'b1;
        end
        OP_MUL: begin
          den <= DEN_W'(ppr) * DEN_W'(sum);
        end
        OP_ROUND: begin
          nreg <= N_W'(num) + N_W'(den >> 1);
        end
        OP_SATCHK: begin
          rem    <= DEN_W'(nreg[N_W-1:Q_W]);
          qreg   <= nreg[Q_W-1:0];
          bitcnt <= '0;
        end
        OP_DIV: begin
          rem    <= trial_ge ? DEN_W'(trial - N_W'(den)) : DEN_W'(trial);
          qreg   <= {qreg[Q_W-2:0], trial_ge};
          bitcnt <= bitcnt + 1'b1;
        end
        OP_OUTQ: begin
          speed_q16    <= qreg;
          no_data      <= 1'b0;
          samples_used <= SAMPLES_W'(count);
          count        <= '0;
          phase        <= 1'b0;
        end
        OP_EMPTY: begin
          speed_q16    <= '0;
          no_data      <= 1'b1;
          samples_used <= '0;
          count        <= '0;
          phase        <= 1'b0;
        end
        OP_OUTSAT: begin
          speed_q16    <= '1;
          no_data      <= 1'b0;
          samples_used <= SAMPLES_W'(count);
          count        <= '0;
          phase        <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_query_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_QUERY)) |=> busy)
    else $error("query accepted but sequencer stayed idle");

  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!busy && (count == '0) && !phase))
    else $error("result strobed without returning to idle and clearing");

  a_no_data_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && no_data) |-> ((speed_q16 == '0) && (samples_used == '0)))
    else $error("no-data result carries nonzero fields");

  a_data_has_samples: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !no_data) |-> (samples_used != '0))
    else $error("speed result with zero samples");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

endmodule

/* src/epsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module epsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
